/* rtl/mdaac_pkg.sv */
package mdaac_pkg;

    // Table sizes.
    localparam int NUM_ARRAYS = 16;
    localparam int MAX_DIMS   = 10;
    localparam int COEFF_ROW  = MAX_DIMS + 1;

    // Field widths fixed by the item format.
    localparam int ID_W  = 4;
    localparam int DIM_W = 4;
    localparam int CUR_W = DIM_W;

    // Memory depths and address widths.
    localparam int BND_DEPTH = NUM_ARRAYS * MAX_DIMS;
    localparam int BND_AW    = $clog2(BND_DEPTH);
    localparam int CF_DEPTH  = NUM_ARRAYS * COEFF_ROW;
    localparam int CF_AW     = $clog2(CF_DEPTH);

    // Item function codes.
    localparam logic [1:0] FUNC_DEFINE = 2'd0;
    localparam logic [1:0] FUNC_BOUND  = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    // Per-array header entry.
    typedef struct packed {
        logic [DIM_W-1:0] dims;
        logic [31:0]      base;
        logic [30:0]      size;
    } hdr_t;

    // Per-dimension bound pair.
    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
    } bnd_t;

endpackage

/* rtl/multi_dim_array_address_calc.sv */
// Row-major array address calculator with a table of up to 16 array descriptors. A define
// beat (func 0) records base, element size and dimension count (0 acts as 1, above 10
// saturates), then one bound beat (func 1) per dimension follows; the last bound triggers
// a coefficient pass that walks the dimensions from the innermost outward through one
// shared 32x32 multiplier, and the folded base constant is written at the end. Query
// beats (func 2) bring one index each, and the last index of an array yields
// result_array and a 32-bit wrapped address. All table state lives in three simple
// dual-port synchronous memories (headers, bounds, coefficients) with registered reads,
// and the block handles one beat at a time. Func code 3 is ignored. A finished address
// waits in an output register, and only the last index of the next query stalls on it.
module multi_dim_array_address_calc (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  func,
    input  logic [mdaac_pkg::ID_W-1:0]  array_id,
    input  logic signed [31:0]          base_address,
    input  logic [30:0]                 elem_size,
    input  logic [mdaac_pkg::DIM_W-1:0] dim_count,
    input  logic signed [31:0]          lower_bound,
    input  logic signed [31:0]          upper_bound,
    input  logic signed [31:0]          index_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mdaac_pkg::ID_W-1:0]  result_array,
    output logic signed [31:0]          address
);
    import mdaac_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEF_HDR,
        S_DEF_SZ,
        S_BND,
        S_FIN_RD,
        S_FIN_LO,
        S_FIN_SUB,
        S_FIN_WR,
        S_FIN_C0,
        S_QRD,
        S_QBASE,
        S_QBASE2,
        S_QCOEF,
        S_QMUL,
        S_QACC
    } state_t;

    state_t state_reg;

    // Beat payload captured at acceptance.
    logic [ID_W-1:0]  id_reg;
    logic [DIM_W-1:0] dims_reg;
    logic [31:0]      base_reg;
    logic [30:0]      size_reg;
    logic [31:0]      lo_reg;
    logic [31:0]      hi_reg;
    logic [31:0]      idx_reg;

    // Cursors, accumulators and output register.
    logic [CUR_W-1:0] define_cursor_reg;
    logic [CUR_W-1:0] query_cursor_reg;
    logic [31:0]      sum_reg;
    logic [CUR_W-1:0] k_reg;
    logic [31:0]      c_reg;
    logic [31:0]      acc_reg;
    logic [31:0]      diff_reg;
    logic [31:0]      prod_reg;
    logic [CUR_W-1:0] qpos_reg;
    logic             qlast_reg;
    logic             out_valid_reg;
    logic [ID_W-1:0]  result_array_reg;
    logic [31:0]      address_reg;

    // Memories and their read data registers.
    hdr_t        hdr_mem [NUM_ARRAYS];
    bnd_t        bnd_mem [BND_DEPTH];
    logic [31:0] cf_mem  [CF_DEPTH];
    hdr_t        hdr_q;
    bnd_t        bnd_q;
    logic [31:0] cf_q;

    logic              in_fire;
    logic              res_load;
    logic [ID_W-1:0]   hdr_rd_addr;
    logic              hdr_we;
    logic [BND_AW-1:0] bnd_row;
    logic [BND_AW-1:0] bnd_rd_addr;
    logic [BND_AW-1:0] bnd_wa;
    logic              bnd_we;
    logic [CF_AW-1:0]  cf_row;
    logic [CF_AW-1:0]  cf_rd_addr;
    logic [CF_AW-1:0]  cf_wa;
    logic [31:0]       cf_wd;
    logic              cf_we;
    logic [DIM_W-1:0]  d_eff;
    logic [CUR_W-1:0]  bpos;
    logic [CUR_W-1:0]  qpos;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [31:0]       mul_p;
    logic [31:0]       sum_next;

    // Dimension count clamped to the supported range.
    function automatic logic [DIM_W-1:0] clamp_dims(input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0] r;
        r = n;
        if (n == '0)
        begin
            r = DIM_W'(1);
        end
        else if (n > DIM_W'(MAX_DIMS))
        begin
            r = DIM_W'(MAX_DIMS);
        end
        return r;
    endfunction

    assign in_ready     = (state_reg == S_IDLE);
    assign in_fire      = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign result_array = result_array_reg;
    assign address      = address_reg;

    // The final accumulate loads the output register once it is free.
    assign res_load = (state_reg == S_QACC) && qlast_reg && (!out_valid_reg || out_ready);

    // Cursor positions against the addressed array's dimension count.
    always_comb
    begin
        d_eff = clamp_dims(hdr_q.dims);
        bpos  = (define_cursor_reg >= d_eff) ? '0 : define_cursor_reg;
        qpos  = (query_cursor_reg >= d_eff) ? '0 : query_cursor_reg;
    end

    // Memory addressing and write control.
    always_comb
    begin
        hdr_rd_addr = (state_reg == S_IDLE) ? array_id : id_reg;
        hdr_we      = (state_reg == S_DEF_HDR);

        bnd_row     = BND_AW'(id_reg * MAX_DIMS);
        bnd_rd_addr = bnd_row + BND_AW'(k_reg);
        bnd_wa      = bnd_row + BND_AW'(bpos);
        bnd_we      = (state_reg == S_BND);

        cf_row = CF_AW'(id_reg * COEFF_ROW);
        if (state_reg == S_QBASE)
        begin
            cf_rd_addr = cf_row;
        end
        else
        begin
            cf_rd_addr = cf_row + CF_AW'(qpos_reg) + CF_AW'(1);
        end

        cf_we = 1'b0;
        cf_wa = cf_row;
        cf_wd = base_reg;
        unique case (state_reg)
            S_DEF_HDR:
            begin
                cf_we = 1'b1;
            end
            S_DEF_SZ:
            begin
                cf_we = 1'b1;
                cf_wa = cf_row + CF_AW'(dims_reg);
                cf_wd = {1'b0, size_reg};
            end
            S_FIN_WR:
            begin
                cf_we = 1'b1;
                cf_wa = cf_row + CF_AW'(k_reg);
                cf_wd = prod_reg;
            end
            S_FIN_C0:
            begin
                cf_we = 1'b1;
                cf_wd = acc_reg;
            end
            default:
            begin
                cf_we = 1'b0;
            end
        endcase
    end

    // Shared multiplier, low 32 bits of the product.
    always_comb
    begin
        unique case (state_reg)
            S_FIN_LO:
            begin
                mul_a = c_reg;
                mul_b = bnd_q.lo;
            end
            S_QMUL:
            begin
                mul_a = cf_q;
                mul_b = idx_reg;
            end
            default:
            begin
                mul_a = c_reg;
                mul_b = diff_reg;
            end
        endcase
        mul_p    = mul_a * mul_b;
        sum_next = sum_reg + prod_reg;
    end

    // Header memory.
    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_mem[id_reg] <= '{dims: dims_reg, base: base_reg, size: size_reg};
        end
        hdr_q <= hdr_mem[hdr_rd_addr];
    end

    // Bound memory.
    always_ff @(posedge clk)
    begin
        if (bnd_we)
        begin
            bnd_mem[bnd_wa] <= '{lo: lo_reg, hi: hi_reg};
        end
        bnd_q <= bnd_mem[bnd_rd_addr];
    end

    // Coefficient memory.
    always_ff @(posedge clk)
    begin
        if (cf_we)
        begin
            cf_mem[cf_wa] <= cf_wd;
        end
        cf_q <= cf_mem[cf_rd_addr];
    end

    // Beat capture.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            id_reg   <= array_id;
            dims_reg <= clamp_dims(dim_count);
            base_reg <= base_address;
            size_reg <= elem_size;
            lo_reg   <= lower_bound;
            hi_reg   <= upper_bound;
            idx_reg  <= index_value;
        end
    end

    // Sequencer with cursors, accumulators and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            define_cursor_reg <= '0;
            query_cursor_reg  <= '0;
            sum_reg           <= '0;
            k_reg             <= '0;
            c_reg             <= '0;
            acc_reg           <= '0;
            diff_reg          <= '0;
            prod_reg          <= '0;
            qpos_reg          <= '0;
            qlast_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
            result_array_reg  <= '0;
            address_reg       <= '0;
        end
        else
        begin
            // Output valid rises with a new address and falls when the beat leaves.
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        unique case (func)
                            FUNC_DEFINE: state_reg <= S_DEF_HDR;
                            FUNC_BOUND:  state_reg <= S_BND;
                            FUNC_QUERY:  state_reg <= S_QRD;
                            default:     state_reg <= S_IDLE;
                        endcase
                    end
                end

                // Header and raw base go in first, element size at the last slot next.
                S_DEF_HDR:
                begin
                    define_cursor_reg <= '0;
                    state_reg         <= S_DEF_SZ;
                end
                S_DEF_SZ:
                begin
                    state_reg <= S_IDLE;
                end

                // Bound pair is written; the last one starts the coefficient pass.
                S_BND:
                begin
                    if (bpos == d_eff - DIM_W'(1))
                    begin
                        define_cursor_reg <= '0;
                        k_reg             <= CUR_W'(d_eff - DIM_W'(1));
                        c_reg             <= {1'b0, hdr_q.size};
                        acc_reg           <= hdr_q.base;
                        state_reg         <= S_FIN_RD;
                    end
                    else
                    begin
                        define_cursor_reg <= bpos + CUR_W'(1);
                        state_reg         <= S_IDLE;
                    end
                end

                // One dimension per pass, innermost first.
                S_FIN_RD:
                begin
                    state_reg <= S_FIN_LO;
                end
                S_FIN_LO:
                begin
                    diff_reg  <= bnd_q.hi - bnd_q.lo + 32'd1;
                    prod_reg  <= mul_p;
                    state_reg <= S_FIN_SUB;
                end
                S_FIN_SUB:
                begin
                    acc_reg  <= acc_reg - prod_reg;
                    prod_reg <= mul_p;
                    if (k_reg == '0)
                    begin
                        state_reg <= S_FIN_C0;
                    end
                    else
                    begin
                        state_reg <= S_FIN_WR;
                    end
                end
                S_FIN_WR:
                begin
                    c_reg     <= prod_reg;
                    k_reg     <= k_reg - CUR_W'(1);
                    state_reg <= S_FIN_RD;
                end
                S_FIN_C0:
                begin
                    state_reg <= S_IDLE;
                end

                // Query: optional base load, then one multiply-accumulate.
                S_QRD:
                begin
                    qpos_reg  <= qpos;
                    qlast_reg <= (qpos == CUR_W'(d_eff - DIM_W'(1)));
                    if (qpos == '0)
                    begin
                        state_reg <= S_QBASE;
                    end
                    else
                    begin
                        state_reg <= S_QCOEF;
                    end
                end
                S_QBASE:
                begin
                    state_reg <= S_QBASE2;
                end
                S_QBASE2:
                begin
                    sum_reg   <= cf_q;
                    state_reg <= S_QMUL;
                end
                S_QCOEF:
                begin
                    state_reg <= S_QMUL;
                end
                S_QMUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_QACC;
                end
                S_QACC:
                begin
                    if (!qlast_reg)
                    begin
                        sum_reg          <= sum_next;
                        query_cursor_reg <= qpos_reg + CUR_W'(1);
                        state_reg        <= S_IDLE;
                    end
                    else if (res_load)
                    begin
                        sum_reg          <= sum_next;
                        query_cursor_reg <= '0;
                        result_array_reg <= id_reg;
                        address_reg      <= sum_next;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // No memory write may coincide with the acceptance of a new beat.
    a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !(hdr_we || bnd_we || cf_we))
        else $error("memory write overlaps beat acceptance");

    // A result appears only from the final accumulate of a query.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_QACC && qlast_reg))
        else $error("result raised outside the final query accumulate");

    // Each coefficient write steps the pass one dimension outward.
    a_fin_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN_WR) |=>
            (state_reg == S_FIN_RD && k_reg == $past(k_reg) - CUR_W'(1)))
        else $error("coefficient pass did not step its dimension counter");

    // Cursors stay inside one descriptor row.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (define_cursor_reg < CUR_W'(MAX_DIMS)) && (query_cursor_reg < CUR_W'(MAX_DIMS)))
        else $error("cursor beyond the dimension range");
`endif

endmodule
